[design/ppcpf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcpf_pkg
// shared types and constants for the packet protocol counter and port filter
// ----------------------------------------------------------------------------
package ppcpf_pkg;

  localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
  localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
  localparam logic [7:0]  L4_TCP     = 8'd6;
  localparam logic [7:0]  L4_UDP     = 8'd17;
  localparam logic [7:0]  L4_ICMP    = 8'd1;
  localparam logic [7:0]  L4_ICMP6   = 8'd58;
  localparam logic [6:0]  POS_MAX    = 7'd127;
  localparam logic [6:0]  IPV6_L4_OFFSET = 7'd54;

  localparam logic [1:0] CLS_TCP   = 2'd0;
  localparam logic [1:0] CLS_UDP   = 2'd1;
  localparam logic [1:0] CLS_ICMP  = 2'd2;
  localparam logic [1:0] CLS_OTHER = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        drop;
    logic        counted;
    logic [1:0]  proto_class;
    logic [63:0] class_count;
  } out_item_t;

  // header fields as they stand after the current byte
  typedef struct packed {
    logic [7:0]  frame_len;
    logic [15:0] ether_type;
    logic [7:0]  ip_protocol;
    logic [6:0]  l4_offset;
    logic [15:0] dest_port;
  } frame_info_t;

endpackage

[design/ppcpf_parse.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcpf_parse
// per-frame byte position and header field capture
// ----------------------------------------------------------------------------
module ppcpf_parse (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   step,
  input  ppcpf_pkg::in_item_t    item,
  output ppcpf_pkg::frame_info_t info
);

  logic [6:0]  byte_position;
  logic [15:0] ether_type;
  logic [7:0]  ip_protocol;
  logic [6:0]  l4_offset;
  logic [15:0] dest_port;

  logic [6:0]  byte_position_next;
  logic [15:0] ether_type_next;
  logic [7:0]  ip_protocol_next;
  logic [6:0]  l4_offset_next;
  logic [15:0] dest_port_next;
  logic [7:0]  pos_wide;
  logic [7:0]  l4_wide;
  logic        is_ipv4;
  logic        is_ipv6;

  always_comb begin
    pos_wide = {1'b0, byte_position};
    l4_wide  = {1'b0, l4_offset};
    is_ipv4  = (ether_type == ppcpf_pkg::ETYPE_IPV4);
    is_ipv6  = (ether_type == ppcpf_pkg::ETYPE_IPV6);

    ether_type_next = ether_type;
    if (byte_position == 7'd12) begin
      ether_type_next = {item.data_byte, 8'h00};
    end else if (byte_position == 7'd13) begin
      ether_type_next = {ether_type[15:8], item.data_byte};
    end

    l4_offset_next = l4_offset;
    if (byte_position == 7'd14) begin
      if (is_ipv4) begin
        l4_offset_next = 7'd14 + {1'b0, item.data_byte[3:0], 2'b00};
      end else if (is_ipv6) begin
        l4_offset_next = ppcpf_pkg::IPV6_L4_OFFSET;
      end
    end

    ip_protocol_next = ip_protocol;
    if ((byte_position == 7'd23 && is_ipv4) || (byte_position == 7'd20 && is_ipv6)) begin
      ip_protocol_next = item.data_byte;
    end

    // l4_offset only changes at byte 14, below the earliest port byte
    dest_port_next = dest_port;
    if (byte_position >= 7'd16 && pos_wide == l4_wide + 8'd2) begin
      dest_port_next = {item.data_byte, 8'h00};
    end else if (byte_position >= 7'd16 && pos_wide == l4_wide + 8'd3) begin
      dest_port_next = {dest_port[15:8], item.data_byte};
    end

    if (byte_position == ppcpf_pkg::POS_MAX) begin
      byte_position_next = byte_position;
    end else begin
      byte_position_next = byte_position + 7'd1;
    end

    info.frame_len   = pos_wide + 8'd1;
    info.ether_type  = ether_type_next;
    info.ip_protocol = ip_protocol_next;
    info.l4_offset   = l4_offset_next;
    info.dest_port   = dest_port_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      ether_type    <= '0;
      ip_protocol   <= '0;
      l4_offset     <= '0;
      dest_port     <= '0;
    end else if (step) begin
      if (item.last_byte) begin
        byte_position <= '0;
        ether_type    <= '0;
        ip_protocol   <= '0;
        l4_offset     <= '0;
        dest_port     <= '0;
      end else begin
        byte_position <= byte_position_next;
        ether_type    <= ether_type_next;
        ip_protocol   <= ip_protocol_next;
        l4_offset     <= l4_offset_next;
        dest_port     <= dest_port_next;
      end
    end
  end

endmodule

[design/ppcpf_count.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppcpf_count
// frame classification, port verdict and per-class counters
// ----------------------------------------------------------------------------
module ppcpf_count #(
  parameter int COUNTER_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [15:0]            cfg_data,
  input  logic                   frame_end,
  input  ppcpf_pkg::frame_info_t info,
  output ppcpf_pkg::out_item_t   result
);

  logic [15:0]             drop_port;
  logic [COUNTER_BITS-1:0] class_counters [4];
  logic [COUNTER_BITS-1:0] count_next;

  logic       ok;
  logic       is_ip;
  logic [1:0] cls;
  logic       drop;
  logic [7:0] l4_wide;

  always_comb begin
    l4_wide = {1'b0, info.l4_offset};
    ok    = 1'b1;
    is_ip = 1'b0;
    if (info.frame_len < 8'd14) begin
      ok = 1'b0;
    end else if (info.ether_type == ppcpf_pkg::ETYPE_IPV4) begin
      is_ip = 1'b1;
      if (info.frame_len < 8'd34 || l4_wide > info.frame_len) begin
        ok = 1'b0;
      end
    end else if (info.ether_type == ppcpf_pkg::ETYPE_IPV6) begin
      is_ip = 1'b1;
      if (info.frame_len < 8'd54) begin
        ok = 1'b0;
      end
    end

    cls = ppcpf_pkg::CLS_OTHER;
    if (is_ip) begin
      if (info.ip_protocol == ppcpf_pkg::L4_TCP) begin
        cls = ppcpf_pkg::CLS_TCP;
      end else if (info.ip_protocol == ppcpf_pkg::L4_UDP) begin
        cls = ppcpf_pkg::CLS_UDP;
      end else if (info.ip_protocol == ppcpf_pkg::L4_ICMP ||
                   info.ip_protocol == ppcpf_pkg::L4_ICMP6) begin
        cls = ppcpf_pkg::CLS_ICMP;
      end
    end

    drop = 1'b0;
    if (ok && is_ip && drop_port != 16'd0 && info.dest_port == drop_port) begin
      if (cls == ppcpf_pkg::CLS_TCP && l4_wide + 8'd20 <= info.frame_len) begin
        drop = 1'b1;
      end else if (cls == ppcpf_pkg::CLS_UDP && l4_wide + 8'd8 <= info.frame_len) begin
        drop = 1'b1;
      end
    end

    count_next = class_counters[cls] + COUNTER_BITS'(1);

    if (ok) begin
      result.drop        = drop;
      result.counted     = 1'b1;
      result.proto_class = cls;
      result.class_count = 64'(count_next);
    end else begin
      result = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drop_port <= '0;
    end else if (cfg_write) begin
      drop_port <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        class_counters[i] <= '0;
      end
    end else if (frame_end && ok) begin
      class_counters[cls] <= count_next;
    end
  end

endmodule

[design/packet_protocol_counter_port_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_protocol_counter_port_filter
// ethernet frame classifier with per-protocol counters and an l4
// destination port filter; one frame byte per item
// ----------------------------------------------------------------------------
//
//   channel  | handshake                      | payload
//   ---------+--------------------------------+---------------------------
//   frame    | frame_valid / frame_ready      | frame_item  (byte, last)
//   result   | result_valid / result_ready    | result_item (verdict, count)
//   cfg      | cfg_valid / cfg_ready (always) | cfg_data    (blocked port)
//
// one item per cycle sustained, unless a last-byte item stalls; an item goes from acceptance
// to its result through the input register, then parse and count into the result register
// only a last-byte item makes a result; other bytes just update header state
// a last-byte item waits in the input register while the result register is
// full and not being taken; other bytes never stall
// synchronous reset clears the frame state, counters and blocked port
// ----------------------------------------------------------------------------
module packet_protocol_counter_port_filter #(
  parameter int COUNTER_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 frame_valid,
  output logic                 frame_ready,
  input  ppcpf_pkg::in_item_t  frame_item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output ppcpf_pkg::out_item_t result_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [15:0]          cfg_data
);

  // input register
  logic                stage_valid;
  ppcpf_pkg::in_item_t stage_item;
  logic                stage_fire;

  // parse and count outputs
  ppcpf_pkg::frame_info_t info;
  ppcpf_pkg::out_item_t   result;

  // a byte moves on unless it is a frame end and the result slot is blocked
  assign stage_fire  = stage_valid &&
                       (!stage_item.last_byte || !result_valid || result_ready);
  assign frame_ready = !stage_valid || stage_fire;
  assign cfg_ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (frame_valid && frame_ready) begin
      stage_valid <= 1'b1;
    end else if (stage_fire) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid && frame_ready) begin
      stage_item <= frame_item;
    end
  end

  ppcpf_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .step (stage_fire),
    .item (stage_item),
    .info (info)
  );

  ppcpf_count #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_count (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .frame_end (stage_fire && stage_item.last_byte),
    .info      (info),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (stage_fire && stage_item.last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && stage_item.last_byte) begin
      result_item <= result;
    end
  end

  // an input byte only holds when a frame end meets a full, stalled result slot
  assert property (@(posedge clk) disable iff (rst)
    stage_valid && !stage_fire |-> stage_item.last_byte && result_valid && !result_ready)
    else $error("input register stalled without a blocked result");

  // a fresh result needs a frame end in the cycle before
  assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid) |-> $past(stage_fire && stage_item.last_byte))
    else $error("result appeared without a frame end");

  // only counted tcp or udp frames are dropped
  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_item.drop |-> result_item.counted &&
      (result_item.proto_class == ppcpf_pkg::CLS_TCP ||
       result_item.proto_class == ppcpf_pkg::CLS_UDP))
    else $error("drop on a frame that is not counted tcp or udp");

  // uncounted frames carry zero class and count
  assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_item.counted |->
      result_item.proto_class == ppcpf_pkg::CLS_TCP && result_item.class_count == 64'd0)
    else $error("short frame result carries class or count");

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// bench for the frame classifier, protocol counters and port filter: frames
// go in one byte per item, and every verdict is checked field by field
// against a predictor that tracks the header state, the per-class counters
// and the blocked port
// ----------------------------------------------------------------------------
module tb_top;

  // no-progress limit, far above the longest receiver hold-off
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD      = 120;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 frame_valid = 1'b0;
  logic                 frame_ready;
  ppcpf_pkg::in_item_t  frame_item = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  ppcpf_pkg::out_item_t result_item;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [15:0]          cfg_data = 16'h0000;

  packet_protocol_counter_port_filter dut (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frame_valid),
    .frame_ready  (frame_ready),
    .frame_item   (frame_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  // 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state: per-frame header capture, counters, blocked port
  logic [6:0]  pos_q     = '0;
  logic [15:0] etype_q   = '0;
  logic [7:0]  proto_q   = '0;
  logic [6:0]  l4_q      = '0;
  logic [15:0] port_q    = '0;
  logic [63:0] class_cnt [4] = '{default: '0};
  logic [15:0] blocked_q = '0;

  // verdicts still owed by the block, oldest first
  ppcpf_pkg::out_item_t expected_verdicts[$];

  bit          idle_on = 1'b1;
  int          long_hold_cycles = 0;
  int unsigned err_count = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned results_seen = 0;
  int unsigned drops_seen = 0;
  int unsigned uncounted_seen = 0;
  int unsigned class_seen [4] = '{default: 0};
  int unsigned quiet_cycles = 0;

  // advance the frame parser by one accepted byte; returns 1 with the
  // verdict when the byte closes a frame
  function automatic bit predict_verdict(input logic [7:0] b, input logic last,
                                         output ppcpf_pkg::out_item_t verdict);
    int unsigned p, len, l4;
    bit ok, ip_frame, drop_it;
    logic [1:0] cls;
    verdict = '0;
    p = pos_q;
    // ethertype is big endian at bytes 12..13, ihl sits in byte 14
    if (p == 12)
      etype_q = {b, 8'h00};
    else if (p == 13)
      etype_q[7:0] = b;
    else if (p == 14) begin
      if (etype_q == ppcpf_pkg::ETYPE_IPV4)
        l4_q = 7'(14 + 4 * b[3:0]);
      else if (etype_q == ppcpf_pkg::ETYPE_IPV6)
        l4_q = ppcpf_pkg::IPV6_L4_OFFSET;
    end
    if ((p == 23 && etype_q == ppcpf_pkg::ETYPE_IPV4) ||
        (p == 20 && etype_q == ppcpf_pkg::ETYPE_IPV6))
      proto_q = b;
    // destination port follows the source port; a new high byte clears the low
    if (p >= 16 && p == l4_q + 2)
      port_q = {b, 8'h00};
    else if (p >= 16 && p == l4_q + 3)
      port_q[7:0] = b;
    if (pos_q < ppcpf_pkg::POS_MAX)
      pos_q = pos_q + 7'd1;
    if (!last)
      return 1'b0;

    len      = p + 1;
    l4       = l4_q;
    ok       = 1'b1;
    drop_it  = 1'b0;
    cls      = ppcpf_pkg::CLS_OTHER;
    ip_frame = (etype_q == ppcpf_pkg::ETYPE_IPV4) || (etype_q == ppcpf_pkg::ETYPE_IPV6);
    // length checks at each header boundary; a short frame is not counted
    if (len < 14)
      ok = 1'b0;
    else if (etype_q == ppcpf_pkg::ETYPE_IPV4)
      ok = (len >= 34) && (l4 <= len);
    else if (etype_q == ppcpf_pkg::ETYPE_IPV6)
      ok = (len >= 54);
    if (ok && ip_frame) begin
      case (proto_q)
        ppcpf_pkg::L4_TCP:                     cls = ppcpf_pkg::CLS_TCP;
        ppcpf_pkg::L4_UDP:                     cls = ppcpf_pkg::CLS_UDP;
        ppcpf_pkg::L4_ICMP, ppcpf_pkg::L4_ICMP6: cls = ppcpf_pkg::CLS_ICMP;
        default:                               cls = ppcpf_pkg::CLS_OTHER;
      endcase
      // drop only with a complete l4 header
      if (blocked_q != 16'h0000 && port_q == blocked_q)
        drop_it = (cls == ppcpf_pkg::CLS_TCP && l4 + 20 <= len) ||
                  (cls == ppcpf_pkg::CLS_UDP && l4 + 8 <= len);
    end
    if (ok) begin
      class_cnt[cls]      = class_cnt[cls] + 64'd1;
      verdict.drop        = drop_it;
      verdict.counted     = 1'b1;
      verdict.proto_class = cls;
      verdict.class_count = class_cnt[cls];
    end
    pos_q   = '0;
    etype_q = '0;
    proto_q = '0;
    l4_q    = '0;
    port_q  = '0;
    return 1'b1;
  endfunction

  // verdict checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    ppcpf_pkg::out_item_t want;
    if (!rst && result_valid && result_ready) begin
      results_seen++;
      if (result_item.drop)
        drops_seen++;
      if (result_item.counted)
        class_seen[result_item.proto_class]++;
      else
        uncounted_seen++;
      if (expected_verdicts.size() == 0) begin
        $error("verdict with none pending: drop %0d counted %0d class %0d count %0d",
               result_item.drop, result_item.counted, result_item.proto_class,
               result_item.class_count);
        err_count++;
      end else begin
        want = expected_verdicts.pop_front();
        if (result_item.drop !== want.drop) begin
          $error("drop: expected %0d, got %0d", want.drop, result_item.drop);
          err_count++;
        end
        if (result_item.counted !== want.counted) begin
          $error("counted: expected %0d, got %0d", want.counted, result_item.counted);
          err_count++;
        end
        if (result_item.proto_class !== want.proto_class) begin
          $error("proto_class: expected %0d, got %0d", want.proto_class,
                 result_item.proto_class);
          err_count++;
        end
        if (result_item.class_count !== want.class_count) begin
          $error("class_count: expected %0d, got %0d", want.class_count,
                 result_item.class_count);
          err_count++;
        end
      end
    end
  end

  // receiver: random stalls, plus the long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (long_hold_cycles > 0) begin
        result_ready <= 1'b0;
        long_hold_cycles--;
      end else if (stall_left > 0) begin
        result_ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(4, 0) == 0) begin
        result_ready <= 1'b0;
        stall_left = $urandom_range(2, 0);
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // watchdog: ends the run after too long without any handshake
  always @(posedge clk) begin
    if (rst || (frame_valid && frame_ready) || (result_valid && result_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end
    end
  end

  // offer one byte item at a falling edge, hold it until taken; valid stays
  // high on return so back-to-back items need no second drive in one step
  task automatic send_byte(input logic [7:0] b, input logic last);
    ppcpf_pkg::in_item_t  item;
    ppcpf_pkg::out_item_t verdict;
    if (idle_on && $urandom_range(5, 0) == 0) begin
      frame_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(negedge clk);
    end
    item.data_byte = b;
    item.last_byte = last;
    frame_valid <= 1'b1;
    frame_item  <= item;
    do @(posedge clk); while (!frame_ready);
    bytes_sent++;
    if (predict_verdict(b, last, verdict)) begin
      expected_verdicts.push_back(verdict);
      frames_sent++;
    end
    @(negedge clk);
  endtask

  // build a frame of random filler with the header fields laid over it
  task automatic send_frame(input logic [15:0] etype, input logic [3:0] ihl,
                            input logic [7:0] proto, input logic [15:0] port,
                            input int len);
    logic [7:0] bytes_q[$];
    int l4;
    for (int i = 0; i < len; i++)
      bytes_q.push_back(8'($urandom));
    l4 = (etype == ppcpf_pkg::ETYPE_IPV6) ? 54 : 14 + 4 * ihl;
    if (len > 12)
      bytes_q[12] = etype[15:8];
    if (len > 13)
      bytes_q[13] = etype[7:0];
    if (etype == ppcpf_pkg::ETYPE_IPV4) begin
      if (len > 14)
        bytes_q[14] = {4'h4, ihl};
      if (len > 23)
        bytes_q[23] = proto;
    end else if (etype == ppcpf_pkg::ETYPE_IPV6 && len > 20) begin
      bytes_q[20] = proto;
    end
    if (etype == ppcpf_pkg::ETYPE_IPV4 || etype == ppcpf_pkg::ETYPE_IPV6) begin
      if (len > l4 + 2)
        bytes_q[l4 + 2] = port[15:8];
      if (len > l4 + 3)
        bytes_q[l4 + 3] = port[7:0];
    end
    foreach (bytes_q[i])
      send_byte(bytes_q[i], i == bytes_q.size() - 1);
  endtask

  // stop offering and wait for every owed verdict; call at a falling edge
  task automatic drain_verdicts();
    frame_valid <= 1'b0;
    while (expected_verdicts.size() != 0)
      @(negedge clk);
  endtask

  // blocked port write, only with the block idle
  task automatic write_drop_port(input logic [15:0] value);
    drain_verdicts();
    // a non-final byte may still sit in the pipeline
    repeat (4) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    blocked_q = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one random frame, mostly well-formed ip with random content
  task automatic send_random_frame();
    int kind;
    logic [7:0]  proto;
    logic [15:0] port;
    logic [3:0]  ihl;
    kind = $urandom_range(99, 0);
    case ($urandom_range(4, 0))
      0:       proto = ppcpf_pkg::L4_TCP;
      1:       proto = ppcpf_pkg::L4_UDP;
      2:       proto = ppcpf_pkg::L4_ICMP;
      3:       proto = ppcpf_pkg::L4_ICMP6;
      default: proto = 8'($urandom);
    endcase
    port = ($urandom_range(2, 0) != 0) ? blocked_q : 16'($urandom);
    ihl  = ($urandom_range(9, 0) != 0) ? 4'd5 : 4'($urandom);
    if (kind < 48)
      send_frame(ppcpf_pkg::ETYPE_IPV4, ihl, proto, port,
                 $urandom_range(14 + 4 * ihl + 24, 30));
    else if (kind < 72)
      send_frame(ppcpf_pkg::ETYPE_IPV6, ihl, proto, port, $urandom_range(76, 50));
    else if (kind < 84)
      send_frame(16'h88CC, ihl, proto, port, $urandom_range(40, 1));
    else if (kind < 88)
      send_frame(ppcpf_pkg::ETYPE_IPV4, ihl, proto, port, $urandom_range(160, 120));
    else
      // noise: anything at all in the ethertype
      send_frame(16'($urandom), ihl, proto, port, $urandom_range(60, 1));
  endtask

  // too short at each header boundary, drop disabled
  task automatic test_short_frames();
    write_drop_port(16'h0000);
    send_byte(8'hFF, 1'b1);
    send_frame(16'h0000, 4'd5, ppcpf_pkg::L4_TCP, 16'h0000, 13);
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd5, ppcpf_pkg::L4_TCP, 16'h0000, 33);
    send_frame(ppcpf_pkg::ETYPE_IPV6, 4'd5, ppcpf_pkg::L4_UDP, 16'h0000, 53);
    // l4 offset beyond the frame end
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd15, ppcpf_pkg::L4_UDP, 16'h0000, 60);
    // port 0 matches the disabled register but must pass
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd5, ppcpf_pkg::L4_UDP, 16'h0000, 42);
  endtask

  // ethertypes that are neither ipv4 nor ipv6 count as other
  task automatic test_non_ip();
    send_frame(16'h0000, 4'd5, ppcpf_pkg::L4_TCP, 16'h0000, 14);
    send_frame(16'h86DC, 4'd5, ppcpf_pkg::L4_TCP, 16'h0000, 20);
  endtask

  task automatic test_ipv4_classes();
    write_drop_port(16'd80);
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd5, ppcpf_pkg::L4_TCP, 16'd80, 54);
    // one byte short of a full tcp header
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd5, ppcpf_pkg::L4_TCP, 16'd80, 53);
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd5, ppcpf_pkg::L4_UDP, 16'd80, 42);
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd5, ppcpf_pkg::L4_ICMP, 16'd80, 34);
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd5, 8'hFF, 16'd80, 34);
  endtask

  task automatic test_ipv6_classes();
    send_frame(ppcpf_pkg::ETYPE_IPV6, 4'd5, ppcpf_pkg::L4_TCP, 16'd80, 74);
    send_frame(ppcpf_pkg::ETYPE_IPV6, 4'd5, ppcpf_pkg::L4_ICMP6, 16'd80, 54);
  endtask

  // ihl below 5 puts the ports inside the ip header; ihl 15 is the far end
  task automatic test_ihl_corners();
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd0, ppcpf_pkg::L4_TCP, 16'd80, 34);
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd1, ppcpf_pkg::L4_UDP, 16'd80, 40);
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd15, ppcpf_pkg::L4_UDP, 16'd80, 82);
  endtask

  // bytes past the position limit are ignored
  task automatic test_long_frames();
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd15, ppcpf_pkg::L4_TCP, 16'd80, 130);
  endtask

  task automatic test_port_extremes();
    write_drop_port(16'hFFFF);
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd5, ppcpf_pkg::L4_TCP, 16'hFFFF, 54);
    write_drop_port(16'h0001);
    send_frame(ppcpf_pkg::ETYPE_IPV4, 4'd5, ppcpf_pkg::L4_UDP, 16'h0001, 42);
  endtask

  // receiver holds off while the sender keeps offering frame-closing items
  task automatic test_result_backpressure();
    long_hold_cycles = LONG_HOLD;
    repeat (12)
      send_frame(16'h1234, 4'd5, ppcpf_pkg::L4_TCP, 16'h0000, $urandom_range(3, 1));
  endtask

  // sender goes quiet until every verdict is in, then resumes
  task automatic test_sender_pause();
    repeat (2) send_random_frame();
    drain_verdicts();
    repeat (2) send_random_frame();
  endtask

  task automatic test_random_traffic(input int byte_goal, input int frame_goal,
                                     input logic [15:0] port);
    int unsigned bytes_start, frames_start;
    write_drop_port(port);
    bytes_start  = bytes_sent;
    frames_start = frames_sent;
    while (bytes_sent - bytes_start < byte_goal || frames_sent - frames_start < frame_goal)
      send_random_frame();
  endtask

  initial begin
    // reset held from the start, released at a falling edge
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_short_frames();
    test_non_ip();
    test_ipv4_classes();
    test_ipv6_classes();
    test_ihl_corners();
    test_long_frames();
    test_port_extremes();
    test_result_backpressure();
    test_sender_pause();
    test_random_traffic(40, 1, 16'($urandom_range(65535, 1)));
    test_random_traffic(40, 1, 16'h0000);
    // last stretch at full rate on both sides
    idle_on = 1'b0;
    test_random_traffic(100, 2, 16'hFFFF);

    drain_verdicts();
    repeat (10) @(posedge clk);
    $display("tb_top: %0d byte items in %0d frames, %0d verdicts, %0d dropped, %0d short",
             bytes_sent, frames_sent, results_seen, drops_seen, uncounted_seen);
    $display("tb_top: counted tcp %0d, udp %0d, icmp %0d, other %0d",
             class_seen[ppcpf_pkg::CLS_TCP], class_seen[ppcpf_pkg::CLS_UDP],
             class_seen[ppcpf_pkg::CLS_ICMP], class_seen[ppcpf_pkg::CLS_OTHER]);
    if (err_count == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

endmodule
